>>> rtl/core/dvfsra_pkg.sv
// ----------------------------------------------------------------------------
// dvfsra_pkg: shared types and codes for DVFS residency accounting
// Request and response payload structs, op codes and reset constants.
// ----------------------------------------------------------------------------
package dvfsra_pkg;

   localparam int LEVELS_DEFAULT = 16;
   localparam int LEVEL_W        = 4;    // width of a level index field
   localparam int CFG_W          = 5;    // width of the level count register
   localparam int TIME_W         = 64;
   localparam int COUNT_W        = 32;

   localparam logic [CFG_W-1:0] LEVEL_COUNT_RESET = 5'd16;

   localparam logic [2:0] OP_START       = 3'd0;
   localparam logic [2:0] OP_UPDATE      = 3'd1;
   localparam logic [2:0] OP_READ_LEVEL  = 3'd2;
   localparam logic [2:0] OP_READ_TRANS  = 3'd3;
   localparam logic [2:0] OP_READ_POWER  = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic [TIME_W-1:0]  timestamp_ns;
      logic [LEVEL_W-1:0] from_level;
      logic [LEVEL_W-1:0] to_level;
      logic               power_on;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [TIME_W-1:0]  time_a;
      logic [TIME_W-1:0]  time_b;
      logic [COUNT_W-1:0] count_a;
      logic [COUNT_W-1:0] count_b;
      logic [TIME_W-1:0]  last_entry_a;
      logic [TIME_W-1:0]  last_entry_b;
   } rsp_type;

endpackage

>>> rtl/core/dvfsra_ram.sv
// ----------------------------------------------------------------------------
// dvfsra_ram: generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dvfsra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/dvfs_residency_accounting_top.sv
// ----------------------------------------------------------------------------
// dvfs_residency_accounting_top: time-in-state statistics for DVFS levels
// Level residency, level entries, transition matrix and power on/off totals.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one operation per transfer (start, update, read level, read
//            transition, read power). req_ready is high only while idle.
//   rsp_*  : exactly one response per request, held in an output register
//            until the receiver takes it; a stalled receiver only holds up
//            the final reply step, the statistics are already updated.
//   csr_*  : level_count write, always ready; user writes between operations, unenforced.
// Steps, from acceptance to the response becoming valid:
//   start, read level, read power, rejected or unknown op : check, reply
//   read transition                                       : check, RAM read, reply
//   update                                                : check, EXEC1 to EXEC4, reply
// A new request is taken at the earliest in the cycle after the response is
// loaded, so the block finishes one request before taking the next. The step
// sequence is set by the single 64-bit adder, which the sequencer uses once
// per step, and by the registered read of the transition RAM.
// Reset: all totals, counts and timestamps clear, level_count returns to 16
// and the transition matrix reads as zero through per-entry valid bits
// (cleared at once, also by every in-range start operation).
// ----------------------------------------------------------------------------
module dvfs_residency_accounting_top #(
   parameter int LEVELS = dvfsra_pkg::LEVELS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dvfsra_pkg::req_type    req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dvfsra_pkg::rsp_type    rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [dvfsra_pkg::CFG_W-1:0] csr_data
);

   import dvfsra_pkg::*;

   // Only indices that fit the 4-bit level fields can ever be addressed.
   localparam int USED   = (LEVELS < (1 << LEVEL_W)) ? LEVELS : (1 << LEVEL_W);
   localparam int IW     = $clog2(USED);
   localparam int TW     = 2 * IW;
   localparam int TDEPTH = 1 << TW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_EXEC1,
      S_EXEC2,
      S_EXEC3,
      S_EXEC4,
      S_REPLY
   } state_type;

   state_type          state_ff;
   req_type            req_ff;
   rsp_type            res_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;
   logic [CFG_W-1:0]   level_count_ff;

   // per-level statistics
   logic [TIME_W-1:0]  lvl_time_ff [USED];
   logic [COUNT_W-1:0] lvl_cnt_ff  [USED];
   logic [TIME_W-1:0]  lvl_last_ff [USED];

   // power statistics and event history
   logic [TIME_W-1:0]  on_time_ff;
   logic [TIME_W-1:0]  off_time_ff;
   logic [COUNT_W-1:0] on_cnt_ff;
   logic [COUNT_W-1:0] off_cnt_ff;
   logic [TIME_W-1:0]  on_last_ff;
   logic [TIME_W-1:0]  off_last_ff;
   logic [TIME_W-1:0]  last_time_ff;
   logic               last_power_ff;
   logic [LEVEL_W-1:0] last_seen_ff;

   // working registers
   logic [TIME_W-1:0]  dt_ff;
   logic [COUNT_W-1:0] trans_cur_ff;
   logic               trans_vld_ff [TDEPTH];

   logic [IW-1:0]      old_idx;
   logic [IW-1:0]      new_idx;
   logic [TW-1:0]      trans_addr;
   logic [COUNT_W-1:0] trans_rdata;
   logic               trans_we;
   logic               old_ok;
   logic               new_ok;
   logic               enter_lvl;

   // result of the check step, and whether more steps follow it
   rsp_type            check_res;
   logic               check_long;

   // shared adder
   logic [TIME_W-1:0]  add_a;
   logic [TIME_W-1:0]  add_b;
   logic               add_cin;
   logic [TIME_W-1:0]  add_sum;

   function automatic logic lvl_ok(input logic [LEVEL_W-1:0] lv,
                                   input logic [CFG_W-1:0]   cnt);
      return (CFG_W'(lv) < cnt) && (32'(lv) < LEVELS);
   endfunction

   assign old_idx    = IW'(req_ff.from_level);
   assign new_idx    = IW'(req_ff.to_level);
   assign trans_addr = {old_idx, new_idx};
   assign old_ok     = lvl_ok(req_ff.from_level, level_count_ff);
   assign new_ok     = lvl_ok(req_ff.to_level, level_count_ff);

   // A level entry is counted on a level change while on, or on power-up
   // into a level other than the last one seen.
   assign enter_lvl = req_ff.power_on &&
                      (last_power_ff ? (req_ff.from_level != req_ff.to_level)
                                     : (last_seen_ff != req_ff.to_level));

   assign trans_we = (state_ff == S_EXEC4) && enter_lvl;

   // update and transition read go on past the check when in range
   assign check_long = (req_ff.op inside {OP_UPDATE, OP_READ_TRANS}) && old_ok && new_ok;

   always_comb begin
      check_res = '0;
      unique case (req_ff.op)
         OP_START: begin
            check_res.status = !new_ok;
         end
         OP_UPDATE: begin
            check_res.status = !(old_ok && new_ok);
         end
         OP_READ_LEVEL: begin
            if (!new_ok) begin
               check_res.status = 1'b1;
            end else begin
               check_res.time_a       = lvl_time_ff[new_idx];
               check_res.count_a      = lvl_cnt_ff[new_idx];
               check_res.last_entry_a = lvl_last_ff[new_idx];
            end
         end
         OP_READ_TRANS: begin
            check_res.status = !(old_ok && new_ok);
         end
         OP_READ_POWER: begin
            check_res.time_a       = on_time_ff;
            check_res.time_b       = off_time_ff;
            check_res.count_a      = on_cnt_ff;
            check_res.count_b      = off_cnt_ff;
            check_res.last_entry_a = on_last_ff;
            check_res.last_entry_b = off_last_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      unique case (state_ff)
         S_CHECK: begin
            if (req_ff.op == OP_START) begin
               add_a   = TIME_W'(lvl_cnt_ff[new_idx]);
               add_cin = 1'b1;
            end else begin
               // elapsed time: now - last event
               add_a   = req_ff.timestamp_ns;
               add_b   = ~last_time_ff;
               add_cin = 1'b1;
            end
         end
         S_EXEC1: begin
            add_a = last_power_ff ? lvl_time_ff[old_idx] : off_time_ff;
            add_b = dt_ff;
         end
         S_EXEC2: begin
            if (last_power_ff) begin
               add_a = on_time_ff;
               add_b = dt_ff;
            end else begin
               add_a   = TIME_W'(on_cnt_ff);
               add_cin = 1'b1;
            end
         end
         S_EXEC3: begin
            add_a   = (last_power_ff && !req_ff.power_on) ? TIME_W'(off_cnt_ff)
                                                          : TIME_W'(lvl_cnt_ff[new_idx]);
            add_cin = 1'b1;
         end
         S_EXEC4: begin
            add_a   = TIME_W'(trans_cur_ff);
            add_cin = 1'b1;
         end
         default: ;
      endcase
   end

   assign add_sum = add_a + add_b + TIME_W'(add_cin);

   dvfsra_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (TDEPTH)
   ) u_trans_ram (
      .clock   (clock),
      .wr_en   (trans_we),
      .wr_addr (trans_addr),
      .wr_data (add_sum[COUNT_W-1:0]),
      .rd_addr (trans_addr),
      .rd_data (trans_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         level_count_ff <= LEVEL_COUNT_RESET;
         on_time_ff     <= '0;
         off_time_ff    <= '0;
         on_cnt_ff      <= '0;
         off_cnt_ff     <= '0;
         on_last_ff     <= '0;
         off_last_ff    <= '0;
         last_time_ff   <= '0;
         last_power_ff  <= 1'b0;
         last_seen_ff   <= '0;
         for (int i = 0; i < USED; i++) begin
            lvl_time_ff[i] <= '0;
            lvl_cnt_ff[i]  <= '0;
            lvl_last_ff[i] <= '0;
         end
         for (int i = 0; i < TDEPTH; i++) begin
            trans_vld_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_valid) begin
            level_count_ff <= csr_data;
         end
         // in S_REPLY the reply step itself reloads the output register
         if (rsp_valid_ff && rsp_ready && (state_ff != S_REPLY)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               res_ff   <= check_res;
               state_ff <= check_long ? S_EXEC1 : S_REPLY;   // transition read waits on RAM
               unique case (req_ff.op)
                  OP_START: begin
                     if (new_ok) begin
                        lvl_cnt_ff[new_idx]  <= add_sum[COUNT_W-1:0];
                        lvl_last_ff[new_idx] <= req_ff.timestamp_ns;
                        last_time_ff         <= req_ff.timestamp_ns;
                        last_power_ff        <= req_ff.power_on;
                        for (int i = 0; i < TDEPTH; i++) begin
                           trans_vld_ff[i] <= 1'b0;
                        end
                     end
                  end
                  OP_UPDATE: begin
                     if (old_ok && new_ok) begin
                        dt_ff <= add_sum;
                     end
                  end
                  default: ;
               endcase
            end
            S_EXEC1: begin
               if (req_ff.op == OP_READ_TRANS) begin
                  res_ff.count_a <= trans_vld_ff[trans_addr] ? trans_rdata : '0;
                  state_ff       <= S_REPLY;
               end else begin
                  if (last_power_ff) begin
                     lvl_time_ff[old_idx] <= add_sum;
                  end else begin
                     off_time_ff <= add_sum;
                  end
                  trans_cur_ff <= trans_vld_ff[trans_addr] ? trans_rdata : '0;
                  state_ff     <= S_EXEC2;
               end
            end
            S_EXEC2: begin
               if (last_power_ff) begin
                  on_time_ff <= add_sum;
               end else if (req_ff.power_on) begin
                  on_cnt_ff  <= add_sum[COUNT_W-1:0];
                  on_last_ff <= req_ff.timestamp_ns;
               end
               state_ff <= S_EXEC3;
            end
            S_EXEC3: begin
               if (last_power_ff && !req_ff.power_on) begin
                  off_cnt_ff  <= add_sum[COUNT_W-1:0];
                  off_last_ff <= req_ff.timestamp_ns;
               end else if (enter_lvl) begin
                  lvl_cnt_ff[new_idx]  <= add_sum[COUNT_W-1:0];
                  lvl_last_ff[new_idx] <= req_ff.timestamp_ns;
               end
               state_ff <= S_EXEC4;
            end
            S_EXEC4: begin
               // on a level entry the transition count is written to the RAM this cycle
               if (enter_lvl) begin
                  trans_vld_ff[trans_addr] <= 1'b1;
               end
               last_power_ff <= req_ff.power_on;
               last_time_ff  <= req_ff.timestamp_ns;
               last_seen_ff  <= req_ff.to_level;
               state_ff      <= S_REPLY;
            end
            S_REPLY: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

>>> rtl/core/dvfsra_checker.sv
// ----------------------------------------------------------------------------
// dvfsra_checker: port-level checks for DVFS residency accounting
// Response holding, busy behavior and rejected-response contents.
// ----------------------------------------------------------------------------
module dvfsra_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  dvfsra_pkg::rsp_type rsp_data
);

   import dvfsra_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one operation at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a new response only comes out of a busy sequencer
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a request in flight");

   // rejected operations return nothing but the status bit
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.time_a == '0 && rsp_data.time_b == '0 &&
         rsp_data.count_a == '0 && rsp_data.count_b == '0 &&
         rsp_data.last_entry_a == '0 && rsp_data.last_entry_b == '0)
      else $error("rejected response carries data");

endmodule

bind dvfs_residency_accounting_top dvfsra_checker u_dvfsra_checker (.*);

>>> verif/dvfsra_residency_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dvfsra_residency_checker: scoreboard for DVFS residency accounting
// Watches the request, response and level count channels, keeps its own copy
// of the residency statistics and compares every response field by field.
// ----------------------------------------------------------------------------
module dvfsra_residency_checker #(
   parameter int LEVELS = dvfsra_pkg::LEVELS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  dvfsra_pkg::req_type          req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  dvfsra_pkg::rsp_type          rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [dvfsra_pkg::CFG_W-1:0] csr_data,
   output int                           fault_count
);
   import dvfsra_pkg::*;

   // shadow statistics
   logic [TIME_W-1:0]  level_ns         [LEVELS];
   logic [COUNT_W-1:0] level_entries    [LEVELS];
   logic [TIME_W-1:0]  level_entered_at [LEVELS];
   logic [COUNT_W-1:0] trans_count      [LEVELS][LEVELS];
   logic [TIME_W-1:0]  on_ns, off_ns, on_since, off_since, event_stamp;
   logic [COUNT_W-1:0] on_entries, off_entries;
   logic               powered;
   logic [LEVEL_W-1:0] last_seen_level;
   logic [CFG_W-1:0]   level_limit;

   rsp_type replies_due[$];
   rsp_type due;
   int      mismatches = 0;

   function automatic bit level_in_use(input logic [LEVEL_W-1:0] lv);
      return (lv < level_limit) && (lv < LEVELS);
   endfunction

   function automatic void enter_level(input logic [LEVEL_W-1:0] from_lvl,
                                       input logic [LEVEL_W-1:0] to_lvl,
                                       input logic [TIME_W-1:0]  at_ns);
      level_entries[to_lvl]          += 1;
      level_entered_at[to_lvl]        = at_ns;
      trans_count[from_lvl][to_lvl]  += 1;
   endfunction

   // apply one operation to the shadow state, return the reply it earns
   function automatic rsp_type account_event(input req_type r);
      rsp_type           res;
      logic [TIME_W-1:0] span;
      bit                old_ok, new_ok;
      res    = '0;
      old_ok = level_in_use(r.from_level);
      new_ok = level_in_use(r.to_level);
      case (r.op)
         OP_START: begin
            if (!new_ok) begin
               res.status = 1'b1;
            end else begin
               event_stamp = r.timestamp_ns;
               powered     = r.power_on;
               foreach (trans_count[i, j]) trans_count[i][j] = '0;
               level_entries[r.to_level]    += 1;
               level_entered_at[r.to_level]  = r.timestamp_ns;
            end
         end
         OP_UPDATE: begin
            if (!(old_ok && new_ok)) begin
               res.status = 1'b1;
            end else begin
               span = r.timestamp_ns - event_stamp;
               if (powered) begin
                  if (r.power_on) begin
                     if (r.from_level != r.to_level)
                        enter_level(r.from_level, r.to_level, r.timestamp_ns);
                  end else begin
                     off_entries += 1;
                     off_since    = r.timestamp_ns;
                  end
                  level_ns[r.from_level] += span;
                  on_ns                  += span;
               end else begin
                  if (r.power_on) begin
                     on_entries += 1;
                     on_since    = r.timestamp_ns;
                     if (last_seen_level != r.to_level)
                        enter_level(r.from_level, r.to_level, r.timestamp_ns);
                  end
                  off_ns += span;
               end
               powered         = r.power_on;
               event_stamp     = r.timestamp_ns;
               last_seen_level = r.to_level;
            end
         end
         OP_READ_LEVEL: begin
            if (!new_ok) begin
               res.status = 1'b1;
            end else begin
               res.time_a       = level_ns[r.to_level];
               res.count_a      = level_entries[r.to_level];
               res.last_entry_a = level_entered_at[r.to_level];
            end
         end
         OP_READ_TRANS: begin
            if (!(old_ok && new_ok)) res.status = 1'b1;
            else res.count_a = trans_count[r.from_level][r.to_level];
         end
         OP_READ_POWER: begin
            res.time_a       = on_ns;
            res.time_b       = off_ns;
            res.count_a      = on_entries;
            res.count_b      = off_entries;
            res.last_entry_a = on_since;
            res.last_entry_b = off_since;
         end
         default: ;  // unused op codes: plain done, nothing touched
      endcase
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            level_ns[i]         = '0;
            level_entries[i]    = '0;
            level_entered_at[i] = '0;
            for (int j = 0; j < LEVELS; j++) trans_count[i][j] = '0;
         end
         on_ns           = '0;
         off_ns          = '0;
         on_since        = '0;
         off_since       = '0;
         event_stamp     = '0;
         on_entries      = '0;
         off_entries     = '0;
         powered         = 1'b0;
         last_seen_level = '0;
         level_limit     = LEVEL_COUNT_RESET;
         replies_due.delete();
      end else begin
         // retire before predicting: a reply never belongs to a request of the same edge
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               $error("response transfer with no request outstanding");
               mismatches++;
            end else begin
               due = replies_due.pop_front();
               check_field("status",       due.status,       rsp_data.status);
               check_field("time_a",       due.time_a,       rsp_data.time_a);
               check_field("time_b",       due.time_b,       rsp_data.time_b);
               check_field("count_a",      due.count_a,      rsp_data.count_a);
               check_field("count_b",      due.count_b,      rsp_data.count_b);
               check_field("last_entry_a", due.last_entry_a, rsp_data.last_entry_a);
               check_field("last_entry_b", due.last_entry_b, rsp_data.last_entry_b);
            end
         end
         if (csr_valid && csr_ready) level_limit = csr_data;
         if (req_valid && req_ready) replies_due.push_back(account_event(req_data));
      end
      // open expectations count as faults once the run has drained
      fault_count <= mismatches + replies_due.size();
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level testbench for DVFS residency accounting
// Directed start/update/read sequences and range rejects, then randomized
// event streams under several level counts, with bursty requests, a stalling
// response side and two long back-pressure windows. The checker scores it.
// ----------------------------------------------------------------------------
module tb;
   import dvfsra_pkg::*;

   localparam int LEVELS = LEVELS_DEFAULT;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CFG_W-1:0]   csr_data  = '0;

   int                 fault_count;
   int                 items_sent = 0;   // request transfers so far
   int                 rsp_total  = 0;   // response transfers so far
   int                 burst_left = 0;
   int                 hold_off_asks = 0; // long stalls asked for by the sender

   // stimulus-side view of the event stream, used only to keep it well formed
   logic [TIME_W-1:0]  now_ns    = '0;
   logic [LEVEL_W-1:0] cur_level = '0;
   logic               cur_power = 1'b0;
   int                 lvl_limit = LEVELS;

   // level counts for the random phases: over-range, minimum, full, zero ...
   logic [CFG_W-1:0]   cfg_plan [8] = '{5'd31, 5'd1, 5'd16, 5'd7, 5'd0, 5'd12, 5'd2, 5'd16};

   dvfs_residency_accounting_top #(.LEVELS(LEVELS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   dvfsra_residency_checker #(.LEVELS(LEVELS)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fault_count (fault_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

   // Response transfers seen; NBA-updated so the stimulus reads last edge's count.
   always @(posedge clock) begin
      if (reset) rsp_total <= 0;
      else if (rsp_valid && rsp_ready) rsp_total <= rsp_total + 1;
   end

   // ------------------------------------------------------------------------
   // Receiver: runs of steady ready, short stalls and coin-flip cycles.
   // On request it holds off for a long stretch so the block backs up and
   // the sender sits on a blocked request transfer.
   // ------------------------------------------------------------------------
   initial begin
      int run_left;
      int mode;
      int holds_done;
      run_left   = 0;
      mode       = 0;
      holds_done = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off_asks != holds_done) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         if (run_left == 0) begin
            mode     = $urandom_range(0, 3);
            run_left = (mode == 1) ? $urandom_range(1, 6) : $urandom_range(1, 40);
         end
         run_left--;
         case (mode)
            1:       rsp_ready <= 1'b0;
            2:       rsp_ready <= 1'($urandom);
            default: rsp_ready <= 1'b1;
         endcase
         @(posedge clock);
      end
   end

   // ------------------------------------------------------------------------
   // Sender helpers
   // ------------------------------------------------------------------------

   // Bursts of back-to-back offers separated by random gaps; returns right
   // after the accepting edge with valid still high.
   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_op(input logic [2:0] op, input logic [TIME_W-1:0] ts,
                          input logic [LEVEL_W-1:0] old_lvl,
                          input logic [LEVEL_W-1:0] new_lvl, input logic pwr);
      req_type it;
      it.op           = op;
      it.timestamp_ns = ts;
      it.from_level   = old_lvl;
      it.to_level     = new_lvl;
      it.power_on     = pwr;
      send_item(it);
   endtask

   // Drop valid, wait for every reply to drain, then write the level count.
   task automatic write_level_count(input logic [CFG_W-1:0] value);
      req_valid <= 1'b0;
      while (rsp_total != items_sent) @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      lvl_limit = (value < LEVELS) ? int'(value) : LEVELS;
      burst_left = 0;
   endtask

   // Mostly a level in use; now and then any index, which may be rejected.
   function automatic logic [LEVEL_W-1:0] pick_level();
      if (lvl_limit == 0 || $urandom_range(0, 19) == 0) return LEVEL_W'($urandom);
      return LEVEL_W'($urandom_range(0, lvl_limit - 1));
   endfunction

   // Event time mostly creeps forward; sometimes stands still or jumps
   // anywhere in 64 bits (backward jumps make the elapsed time wrap).
   function automatic void advance_time();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2)      now_ns = {$urandom, $urandom};
      else if (roll < 5) now_ns = now_ns;
      else               now_ns = now_ns + TIME_W'($urandom_range(1, 20000));
   endfunction

   // One random operation; most are sane update events continuing the stream.
   function automatic req_type random_item();
      req_type it;
      int      pick;
      pick            = $urandom_range(0, 99);
      it.op           = OP_UPDATE;
      it.timestamp_ns = {$urandom, $urandom};
      it.from_level   = LEVEL_W'($urandom);
      it.to_level     = LEVEL_W'($urandom);
      it.power_on     = 1'($urandom);
      if (pick < 3) begin
         advance_time();
         it.op           = OP_START;
         it.timestamp_ns = now_ns;
         it.to_level     = pick_level();
         cur_level       = it.to_level;
         cur_power       = it.power_on;
      end else if (pick < 58) begin
         advance_time();
         it.timestamp_ns = now_ns;
         it.from_level   = ($urandom_range(0, 9) == 0) ? pick_level() : cur_level;
         it.to_level     = ($urandom_range(0, 2) == 0) ? cur_level : pick_level();
         it.power_on     = ($urandom_range(0, 3) == 0) ? ~cur_power : cur_power;
         cur_level       = it.to_level;
         cur_power       = it.power_on;
      end else if (pick < 70) begin
         it.op       = OP_READ_LEVEL;
         it.to_level = pick_level();
      end else if (pick < 82) begin
         it.op         = OP_READ_TRANS;
         it.from_level = pick_level();
         it.to_level   = pick_level();
      end else if (pick < 90) begin
         it.op = OP_READ_POWER;
      end else if (pick >= 95) begin
         // codes past the last defined op
         it.op = OP_READ_POWER + 3'($urandom_range(1, 3));
      end
      // remaining picks: update with fully random levels and timestamp
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int n_items;
      wait (!reset);
      @(posedge clock);

      // --- directed: full level range ---
      write_level_count(LEVEL_COUNT_RESET);
      send_op(OP_READ_POWER, '1, 4'd15, 4'd15, 1'b1);        // untouched stats
      send_op(OP_START,  64'd1000, 4'd15, 4'd0,  1'b1);
      send_op(OP_UPDATE, 64'd1500, 4'd0,  4'd15, 1'b1);      // level change while on
      send_op(OP_UPDATE, 64'd2000, 4'd15, 4'd15, 1'b1);      // same level, no entry
      send_op(OP_UPDATE, 64'd2600, 4'd15, 4'd15, 1'b0);      // power off
      send_op(OP_UPDATE, 64'd4000, 4'd15, 4'd3,  1'b1);      // power on at another level
      send_op(OP_UPDATE, 64'd4100, 4'd3,  4'd3,  1'b0);
      send_op(OP_UPDATE, 64'd5000, 4'd3,  4'd3,  1'b1);      // on again at last level seen
      send_op(OP_UPDATE, '1,       4'd3,  4'd0,  1'b1);      // max timestamp
      send_op(OP_UPDATE, 64'd16,   4'd0,  4'd0,  1'b1);      // time runs back: wrap
      send_op(OP_READ_LEVEL, 64'd0, 4'd0, 4'd15, 1'b0);
      send_op(OP_READ_TRANS, 64'd0, 4'd0, 4'd15, 1'b0);
      send_op(OP_READ_TRANS, 64'd0, 4'd15, 4'd3, 1'b0);
      send_op(OP_READ_POWER, 64'd0, 4'd0, 4'd0,  1'b0);
      for (int k = 1; k <= 3; k++)
         send_op(OP_READ_POWER + 3'(k), {$urandom, $urandom}, 4'($urandom),
                 4'($urandom), 1'($urandom));
      send_op(OP_START, 64'd9000, 4'd0, 4'd1, 1'b0);         // clears the matrix
      send_op(OP_READ_TRANS, 64'd0, 4'd0, 4'd15, 1'b0);

      // --- directed: range rejects ---
      write_level_count(5'd4);
      send_op(OP_START,      64'd9100, 4'd0, 4'd4,  1'b1);
      send_op(OP_UPDATE,     64'd9200, 4'd5, 4'd0,  1'b1);
      send_op(OP_UPDATE,     64'd9300, 4'd0, 4'd9,  1'b1);
      send_op(OP_READ_LEVEL, 64'd0,    4'd0, 4'd4,  1'b0);
      send_op(OP_READ_TRANS, 64'd0,    4'd3, 4'd12, 1'b0);
      write_level_count(5'd0);                                // nothing in range
      send_op(OP_START,      64'd9400, 4'd0, 4'd0,  1'b1);
      send_op(OP_READ_LEVEL, 64'd0,    4'd0, 4'd0,  1'b0);
      now_ns = 64'd10000;

      // --- random phases, one level count each ---
      foreach (cfg_plan[p]) begin
         write_level_count(cfg_plan[p]);
         if (p == 0 || p == 3) hold_off_asks++;               // back-pressure window
         n_items = (cfg_plan[p] == 0) ? 60 : 205;
         advance_time();
         send_op(OP_START, now_ns, '0, pick_level(), 1'b1);
         cur_power = 1'b1;
         repeat (n_items) send_item(random_item());
      end

      // --- drain and verdict ---
      req_valid <= 1'b0;
      while (rsp_total != items_sent) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fault_count == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/dvfsra_pkg.sv
rtl/core/dvfsra_ram.sv
rtl/core/dvfs_residency_accounting_top.sv
rtl/core/dvfsra_checker.sv
verif/dvfsra_residency_checker.sv
verif/tb.sv
